/* src/cspm_pkg.sv */
`timescale 1ns / 1ps

package cspm_pkg;

	localparam int TABLE_DEPTH_DEF = 16;
	localparam int MAX_RESULTS     = 16;
	localparam int FOUND_W         = $clog2(MAX_RESULTS + 1);
	localparam int DIV_W           = 6;
	localparam int DIV_UNITS       = 4;

	localparam logic [1:0] ST_INSERTED = 2'd0;
	localparam logic [1:0] ST_FULL     = 2'd1;
	localparam logic [1:0] ST_MATCH    = 2'd2;
	localparam logic [1:0] ST_NOMATCH  = 2'd3;

	typedef enum logic [1:0] {
		KIND_EXACT = 2'd0,
		KIND_ANY   = 2'd1,
		KIND_EVERY = 2'd2
	} kind_t;

	typedef struct packed {
		logic [2:0] weekday;
		logic [4:0] day;
		logic [4:0] hour;
		logic [5:0] minute;
		logic [5:0] second;
	} time_t;

	typedef struct packed {
		kind_t      weekday_kind;
		logic [2:0] weekday_val;
		kind_t      day_kind;
		logic [4:0] day_val;
		kind_t      hour_kind;
		logic [4:0] hour_val;
		kind_t      minute_kind;
		logic [5:0] minute_val;
		kind_t      second_kind;
		logic [5:0] second_val;
	} entry_t;

	typedef struct packed {
		logic       clear;
		logic       step;
		logic       last_step;
		logic [2:0] bit_idx;
		logic       shift;
	} cell_ctrl_t;

	function automatic kind_t norm_kind(input logic [1:0] k);
		kind_t r;
		unique case (k)
			2'd0: r = KIND_EXACT;
			2'd2: r = KIND_EVERY;
			default: r = KIND_ANY;
		endcase
		return r;
	endfunction

	// Once a unit is fixed, every later wildcard unit is pinned to exact zero.
	function automatic entry_t make_entry(input time_t v, input logic [1:0] k_wd,
			input logic [1:0] k_day, input logic [1:0] k_hour,
			input logic [1:0] k_min, input logic [1:0] k_sec);
		entry_t     e;
		kind_t      k [5];
		logic [4:0] zero;
		logic       seen;
		k[0] = norm_kind(k_wd);
		k[1] = norm_kind(k_day);
		k[2] = norm_kind(k_hour);
		k[3] = norm_kind(k_min);
		k[4] = norm_kind(k_sec);
		seen = 1'b0;
		zero = '0;
		for (int u = 0; u < 5; u++) begin
			if (k[u] == KIND_ANY && seen) begin
				k[u] = KIND_EXACT;
				zero[u] = 1'b1;
			end
			if (k[u] != KIND_ANY) begin
				seen = 1'b1;
			end
		end
		e.weekday_kind = k[0];
		e.weekday_val  = zero[0] ? 3'd0 : v.weekday;
		e.day_kind     = k[1];
		e.day_val      = zero[1] ? 5'd0 : v.day;
		e.hour_kind    = k[2];
		e.hour_val     = zero[2] ? 5'd0 : v.hour;
		e.minute_kind  = k[3];
		e.minute_val   = zero[3] ? 6'd0 : v.minute;
		e.second_kind  = k[4];
		e.second_val   = zero[4] ? 6'd0 : v.second;
		return e;
	endfunction

endpackage

/* src/cspm_cell.sv */
`timescale 1ns / 1ps

module cspm_cell (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 wr,
	input  cspm_pkg::entry_t     wr_entry,
	input  cspm_pkg::cell_ctrl_t ctrl,
	input  cspm_pkg::time_t      now,
	input  logic                 active,
	input  logic                 hit_in,
	output logic                 hit_out
);

	cspm_pkg::entry_t entry_q;
	logic             hit_q;

	logic [cspm_pkg::DIV_W-1:0] rem_q  [cspm_pkg::DIV_UNITS];
	logic [cspm_pkg::DIV_W-1:0] rem_nx [cspm_pkg::DIV_UNITS];
	logic [cspm_pkg::DIV_W-1:0] now6   [cspm_pkg::DIV_UNITS];
	logic [cspm_pkg::DIV_W-1:0] val6   [cspm_pkg::DIV_UNITS];
	cspm_pkg::kind_t            kind   [cspm_pkg::DIV_UNITS];
	logic [cspm_pkg::DIV_UNITS-1:0] unit_ok;
	logic                       wd_ok;

	assign now6[0] = {1'b0, now.day};
	assign now6[1] = {1'b0, now.hour};
	assign now6[2] = now.minute;
	assign now6[3] = now.second;
	assign val6[0] = {1'b0, entry_q.day_val};
	assign val6[1] = {1'b0, entry_q.hour_val};
	assign val6[2] = entry_q.minute_val;
	assign val6[3] = entry_q.second_val;
	assign kind[0] = entry_q.day_kind;
	assign kind[1] = entry_q.hour_kind;
	assign kind[2] = entry_q.minute_kind;
	assign kind[3] = entry_q.second_kind;

	for (genvar u = 0; u < cspm_pkg::DIV_UNITS; u++) begin : g_unit
		logic [cspm_pkg::DIV_W:0] trial;

		always_comb begin
			trial = {rem_q[u], now6[u][ctrl.bit_idx]};
			if (trial >= {1'b0, val6[u]}) begin
				rem_nx[u] = cspm_pkg::DIV_W'(trial - {1'b0, val6[u]});
			end else begin
				rem_nx[u] = trial[cspm_pkg::DIV_W-1:0];
			end
			unique case (kind[u])
				cspm_pkg::KIND_EXACT: unit_ok[u] = (now6[u] == val6[u]);
				cspm_pkg::KIND_EVERY: unit_ok[u] = (val6[u] != '0) && (rem_nx[u] == '0);
				default:              unit_ok[u] = 1'b1;
			endcase
		end

		always_ff @(posedge clk) begin
			if (ctrl.clear) begin
				rem_q[u] <= '0;
			end else if (ctrl.step) begin
				rem_q[u] <= rem_nx[u];
			end
		end
	end

	always_comb begin
		unique case (entry_q.weekday_kind)
			cspm_pkg::KIND_EXACT: wd_ok = (now.weekday == entry_q.weekday_val);
			cspm_pkg::KIND_EVERY: wd_ok = 1'b0;
			default:              wd_ok = 1'b1;
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr) begin
			entry_q <= wr_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q <= 1'b0;
		end else if (ctrl.step && ctrl.last_step) begin
			hit_q <= active && wd_ok && (&unit_ok);
		end else if (ctrl.shift) begin
			hit_q <= hit_in;
		end
	end

	assign hit_out = hit_q;

endmodule

/* src/cron_schedule_matcher_core.sv */
`timescale 1ns / 1ps
// Insert: the result is registered in the cycle after the request is taken; one insert per
// cycle while each result is taken. Tick: a bit-serial remainder in every cell (S_DIV), a walk
// of the hit chain (S_SCAN) that ends early once MAX_RESULTS hits are found, stalling while
// a match waits on out_ready, then a flush (S_FLUSH) for the last result.
// One request is worked on at a time; a new one is taken once the last result leaves.
// Asynchronous active-low reset empties the table; stored entries are not cleared.
module cron_schedule_matcher_core #(
	parameter int TABLE_DEPTH = cspm_pkg::TABLE_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic       mode,
	input  logic [2:0] weekday_value,
	input  logic [4:0] day_value,
	input  logic [4:0] hour_value,
	input  logic [5:0] minute_value,
	input  logic [5:0] second_value,
	input  logic [1:0] weekday_kind,
	input  logic [1:0] day_kind,
	input  logic [1:0] hour_kind,
	input  logic [1:0] minute_kind,
	input  logic [1:0] second_kind,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [1:0] status,
	output logic [3:0] entry_index,
	output logic       last
);

	localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CW = $clog2(TABLE_DEPTH + 1);

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_DIV   = 4'b0010,
		S_SCAN  = 4'b0100,
		S_FLUSH = 4'b1000
	} state_t;

	state_t                       state_q;
	logic [CW-1:0]                count_q;
	logic [IW-1:0]                scan_q;
	logic [IW-1:0]                pend_idx_q;
	logic                         pend_valid_q;
	logic [cspm_pkg::FOUND_W-1:0] found_q;
	logic [cspm_pkg::FOUND_W-1:0] found_nx;
	logic [2:0]                   bit_q;
	cspm_pkg::time_t              now_q;
	cspm_pkg::time_t              in_time;
	cspm_pkg::entry_t             new_entry;
	cspm_pkg::cell_ctrl_t         ctrl;

	logic          out_valid_q;
	logic [1:0]    status_q;
	logic [3:0]    index_q;
	logic          last_q;

	logic          in_acc, out_free, full, ins, tick;
	logic          head_hit, scan_last, adv, emit_scan, emit_flush;
	logic [IW+3:0] slot_ext, pend_ext;
	logic [TABLE_DEPTH:0] chain;

	assign in_time   = '{weekday: weekday_value, day: day_value, hour: hour_value,
		minute: minute_value, second: second_value};
	assign new_entry = cspm_pkg::make_entry(in_time, weekday_kind, day_kind, hour_kind,
		minute_kind, second_kind);

	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == S_IDLE) && out_free;
	assign in_acc    = in_valid && in_ready;
	assign full      = (count_q == CW'(TABLE_DEPTH));
	assign ins       = in_acc && !mode;
	assign tick      = in_acc && mode;

	assign head_hit   = chain[0];
	assign scan_last  = (scan_q == IW'(TABLE_DEPTH - 1));
	assign found_nx   = found_q + 1'b1;
	assign adv        = (state_q == S_SCAN) && (!head_hit || !pend_valid_q || out_free);
	assign emit_scan  = (state_q == S_SCAN) && head_hit && pend_valid_q && out_free;
	assign emit_flush = (state_q == S_FLUSH) && out_free;

	assign slot_ext = {4'd0, count_q[IW-1:0]};
	assign pend_ext = {4'd0, pend_idx_q};

	assign ctrl.clear     = tick;
	assign ctrl.step      = (state_q == S_DIV);
	assign ctrl.last_step = (bit_q == 3'd0);
	assign ctrl.bit_idx   = bit_q;
	assign ctrl.shift     = adv;

	assign chain[TABLE_DEPTH] = 1'b0;

	for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
		cspm_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.wr       (ins && !full && (count_q[IW-1:0] == IW'(i))),
			.wr_entry (new_entry),
			.ctrl     (ctrl),
			.now      (now_q),
			.active   (count_q > CW'(i)),
			.hit_in   (chain[i+1]),
			.hit_out  (chain[i])
		);
	end

	always_ff @(posedge clk) begin
		if (tick) begin
			now_q <= in_time;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			count_q      <= '0;
			scan_q       <= '0;
			pend_idx_q   <= '0;
			pend_valid_q <= 1'b0;
			found_q      <= '0;
			bit_q        <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (ins && !full) begin
						count_q <= count_q + 1'b1;
					end
					if (tick) begin
						bit_q        <= 3'(cspm_pkg::DIV_W - 1);
						scan_q       <= '0;
						found_q      <= '0;
						pend_valid_q <= 1'b0;
						state_q      <= S_DIV;
					end
				end
				S_DIV: begin
					bit_q <= bit_q - 1'b1;
					if (bit_q == 3'd0) begin
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (adv) begin
						scan_q <= scan_q + 1'b1;
						if (head_hit) begin
							found_q      <= found_nx;
							pend_valid_q <= 1'b1;
							pend_idx_q   <= scan_q;
						end
						if (scan_last ||
								(head_hit && found_nx == cspm_pkg::FOUND_W'(cspm_pkg::MAX_RESULTS))) begin
							state_q <= S_FLUSH;
						end
					end
				end
				S_FLUSH: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ins || emit_scan || emit_flush) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ins) begin
			status_q <= full ? cspm_pkg::ST_FULL : cspm_pkg::ST_INSERTED;
			index_q  <= full ? 4'd0 : slot_ext[3:0];
			last_q   <= 1'b1;
		end else if (emit_scan) begin
			status_q <= cspm_pkg::ST_MATCH;
			index_q  <= pend_ext[3:0];
			last_q   <= 1'b0;
		end else if (emit_flush) begin
			status_q <= pend_valid_q ? cspm_pkg::ST_MATCH : cspm_pkg::ST_NOMATCH;
			index_q  <= pend_valid_q ? pend_ext[3:0] : 4'd0;
			last_q   <= 1'b1;
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign entry_index = index_q;
	assign last        = last_q;

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(TABLE_DEPTH))
		else $error("entry count beyond table depth");

	a_pend_found: assert property (@(posedge clk) disable iff (!arst_n)
		pend_valid_q |-> (found_q != '0))
		else $error("pending match without a counted hit");

	a_insert_count: assert property (@(posedge clk) disable iff (!arst_n)
		(ins && !full) |=> (count_q == $past(count_q) + 1'b1))
		else $error("accepted insert did not advance the entry count");
`endif

endmodule

/* tb/sv/tb_cron_schedule_matcher_core.sv */
`timescale 1ns / 1ps

module tb_cron_schedule_matcher_core;

	localparam int LIMIT_CYCLES = 1000000;
	localparam int DRAIN_CYCLES = 40;
	localparam logic [1:0] KIND_CODE3 = 2'd3;
	localparam int UNIT_W [5] = '{3, 5, 5, 6, 6};

	// Units are indexed weekday, day, hour, minute, second.
	typedef struct packed {
		logic            mode;
		logic [4:0][5:0] val;
		logic [4:0][1:0] kind;
	} req_t;

	typedef struct packed {
		logic [1:0] status;
		logic [3:0] entry_index;
		logic       last;
	} result_t;

	class schedule_tracker;
		cspm_pkg::kind_t slot_kind [cspm_pkg::TABLE_DEPTH_DEF][5];
		logic [5:0]      slot_val [cspm_pkg::TABLE_DEPTH_DEF][5];
		int unsigned     stored_entries;
		result_t         pending_results [$];
		int unsigned     errors;

		function bit unit_hit(int u, cspm_pkg::kind_t k, logic [5:0] v, logic [5:0] now);
			if (k == cspm_pkg::KIND_EXACT) begin
				return now == v;
			end
			if (k == cspm_pkg::KIND_EVERY) begin
				return u != 0 && v != 0 && (now % v) == 0;
			end
			return 1'b1;
		endfunction

		function void note_request(req_t r);
			cspm_pkg::kind_t k;
			logic [5:0]      v;
			bit              fixed;
			bit              hit;
			int              found;
			if (!r.mode) begin
				if (stored_entries >= cspm_pkg::TABLE_DEPTH_DEF) begin
					pending_results.push_back('{cspm_pkg::ST_FULL, 4'd0, 1'b1});
					return;
				end
				// Once a unit is pinned, later wildcards turn into exact zero.
				fixed = 1'b0;
				for (int u = 0; u < 5; u++) begin
					k = (r.kind[u] == KIND_CODE3) ? cspm_pkg::KIND_ANY :
						cspm_pkg::kind_t'(r.kind[u]);
					v = r.val[u];
					if (k == cspm_pkg::KIND_ANY) begin
						if (fixed) begin
							k = cspm_pkg::KIND_EXACT;
							v = '0;
						end
					end else begin
						fixed = 1'b1;
					end
					slot_kind[stored_entries][u] = k;
					slot_val[stored_entries][u] = v;
				end
				pending_results.push_back('{cspm_pkg::ST_INSERTED, 4'(stored_entries), 1'b1});
				stored_entries++;
				return;
			end
			found = 0;
			for (int e = 0; e < stored_entries && found < cspm_pkg::MAX_RESULTS; e++) begin
				hit = 1'b1;
				for (int u = 0; u < 5; u++) begin
					hit &= unit_hit(u, slot_kind[e][u], slot_val[e][u], r.val[u]);
				end
				if (hit) begin
					pending_results.push_back('{cspm_pkg::ST_MATCH, 4'(e), 1'b0});
					found++;
				end
			end
			if (found == 0) begin
				pending_results.push_back('{cspm_pkg::ST_NOMATCH, 4'd0, 1'b1});
			end else begin
				pending_results[pending_results.size() - 1].last = 1'b1;
			end
		endfunction

		function void check_result(logic [1:0] st, logic [3:0] idx, logic fin);
			result_t want;
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result: status %0d entry_index %0d last %0d",
					$time, st, idx, fin);
				errors++;
				return;
			end
			want = pending_results.pop_front();
			if (st !== want.status) begin
				$display("%0t: status expected %0d, actual %0d", $time, want.status, st);
				errors++;
			end
			if (idx !== want.entry_index) begin
				$display("%0t: entry_index expected %0d, actual %0d",
					$time, want.entry_index, idx);
				errors++;
			end
			if (fin !== want.last) begin
				$display("%0t: last expected %0d, actual %0d", $time, want.last, fin);
				errors++;
			end
		endfunction
	endclass

	logic       clk;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic       mode = 1'b0;
	logic [2:0] weekday_value = '0;
	logic [4:0] day_value = '0;
	logic [4:0] hour_value = '0;
	logic [5:0] minute_value = '0;
	logic [5:0] second_value = '0;
	logic [1:0] weekday_kind = '0;
	logic [1:0] day_kind = '0;
	logic [1:0] hour_kind = '0;
	logic [1:0] minute_kind = '0;
	logic [1:0] second_kind = '0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic [1:0] status;
	logic [3:0] entry_index;
	logic       last;

	schedule_tracker tracker = new();
	bit              idle_on = 1'b1;
	int unsigned     cycles = 0;

	cron_schedule_matcher_core DUT (.*);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == LIMIT_CYCLES) begin
			$display("** cron_schedule_matcher_core: FAILED **");
			$finish;
		end
	end

	always @(posedge clk) begin : watch_ports
		req_t seen;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				seen.mode = mode;
				seen.val[0] = 6'(weekday_value);
				seen.val[1] = 6'(day_value);
				seen.val[2] = 6'(hour_value);
				seen.val[3] = minute_value;
				seen.val[4] = second_value;
				seen.kind[0] = weekday_kind;
				seen.kind[1] = day_kind;
				seen.kind[2] = hour_kind;
				seen.kind[3] = minute_kind;
				seen.kind[4] = second_kind;
				tracker.note_request(seen);
			end
			if (out_valid && out_ready) begin
				tracker.check_result(status, entry_index, last);
			end
		end
	end

	function automatic req_t mk_req(logic m, int wd, int d, int h, int mi, int s,
			logic [1:0] k0, logic [1:0] k1, logic [1:0] k2, logic [1:0] k3,
			logic [1:0] k4);
		req_t r;
		r.mode = m;
		r.val[0] = 6'(wd);
		r.val[1] = 6'(d);
		r.val[2] = 6'(h);
		r.val[3] = 6'(mi);
		r.val[4] = 6'(s);
		r.kind[0] = k0;
		r.kind[1] = k1;
		r.kind[2] = k2;
		r.kind[3] = k3;
		r.kind[4] = k4;
		return r;
	endfunction

	function automatic req_t random_req(logic m);
		req_t r;
		r.mode = m;
		for (int u = 0; u < 5; u++) begin
			r.val[u] = 6'($urandom_range(0, (1 << UNIT_W[u]) - 1));
			r.kind[u] = 2'($urandom_range(0, 3));
		end
		return r;
	endfunction

	// Builds a tick that satisfies one stored entry, now and then with one unit disturbed.
	function automatic req_t aimed_tick();
		req_t       r;
		int         e;
		int         u;
		int         top;
		logic [5:0] v;
		r = random_req(1'b1);
		if (tracker.stored_entries == 0) begin
			return r;
		end
		e = $urandom_range(0, tracker.stored_entries - 1);
		for (int n = 0; n < 5; n++) begin
			top = (1 << UNIT_W[n]) - 1;
			v = tracker.slot_val[e][n];
			if (tracker.slot_kind[e][n] == cspm_pkg::KIND_EXACT) begin
				r.val[n] = v;
			end else if (tracker.slot_kind[e][n] == cspm_pkg::KIND_EVERY && n != 0 &&
					v != 0) begin
				r.val[n] = 6'(v * $urandom_range(0, top / v));
			end
		end
		if ($urandom_range(0, 4) == 0) begin
			u = $urandom_range(0, 4);
			r.val[u] = 6'($urandom_range(0, (1 << UNIT_W[u]) - 1));
		end
		return r;
	endfunction

	task automatic send_request(input req_t r);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
		in_valid <= 1'b1;
		mode <= r.mode;
		weekday_value <= r.val[0][2:0];
		day_value <= r.val[1][4:0];
		hour_value <= r.val[2][4:0];
		minute_value <= r.val[3];
		second_value <= r.val[4];
		weekday_kind <= r.kind[0];
		day_kind <= r.kind[1];
		hour_kind <= r.kind[2];
		minute_kind <= r.kind[3];
		second_kind <= r.kind[4];
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	initial begin
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			if (idle_on && $urandom_range(0, 3) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 15)) @(posedge clk);
			end
			out_ready <= 1'b1;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
	end

	initial begin
		req_t r;
		int   inserts_sent;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// A tick against the empty table finds nothing.
		send_request(mk_req(1'b1, 0, 0, 0, 0, 0, cspm_pkg::KIND_EXACT, cspm_pkg::KIND_EXACT,
			cspm_pkg::KIND_EXACT, cspm_pkg::KIND_EXACT, cspm_pkg::KIND_EXACT));
		send_request(mk_req(1'b0, 3, 15, 12, 30, 45, cspm_pkg::KIND_EXACT,
			cspm_pkg::KIND_EXACT, cspm_pkg::KIND_EXACT, cspm_pkg::KIND_EXACT,
			cspm_pkg::KIND_EXACT));
		send_request(mk_req(1'b0, 0, 0, 23, 17, 9,
			KIND_CODE3, KIND_CODE3, cspm_pkg::KIND_EXACT, cspm_pkg::KIND_ANY, KIND_CODE3));
		send_request(mk_req(1'b0, 0, 0, 0, 0, 0, cspm_pkg::KIND_ANY, cspm_pkg::KIND_EVERY,
			cspm_pkg::KIND_ANY, cspm_pkg::KIND_ANY, cspm_pkg::KIND_ANY));
		send_request(mk_req(1'b0, 2, 0, 0, 0, 0, cspm_pkg::KIND_EVERY, cspm_pkg::KIND_ANY,
			cspm_pkg::KIND_ANY, cspm_pkg::KIND_ANY, cspm_pkg::KIND_ANY));
		send_request(mk_req(1'b0, 7, 31, 31, 63, 63, cspm_pkg::KIND_EXACT,
			cspm_pkg::KIND_EXACT, cspm_pkg::KIND_EXACT, cspm_pkg::KIND_EXACT,
			cspm_pkg::KIND_EXACT));
		send_request(mk_req(1'b0, 0, 0, 6, 15, 1, cspm_pkg::KIND_ANY, cspm_pkg::KIND_ANY,
			cspm_pkg::KIND_EVERY, cspm_pkg::KIND_EVERY, cspm_pkg::KIND_EVERY));
		send_request(mk_req(1'b0, 0, 0, 0, 0, 60, cspm_pkg::KIND_ANY, cspm_pkg::KIND_ANY,
			cspm_pkg::KIND_ANY, cspm_pkg::KIND_ANY, cspm_pkg::KIND_EVERY));
		send_request(mk_req(1'b0, 5, 31, 31, 63, 63, KIND_CODE3, cspm_pkg::KIND_EVERY,
			cspm_pkg::KIND_EVERY, cspm_pkg::KIND_EVERY, cspm_pkg::KIND_EVERY));
		send_request(mk_req(1'b0, 0, 0, 0, 0, 0, cspm_pkg::KIND_EXACT, cspm_pkg::KIND_EXACT,
			cspm_pkg::KIND_EXACT, cspm_pkg::KIND_EXACT, cspm_pkg::KIND_EXACT));
		send_request(mk_req(1'b0, 6, 0, 0, 0, 1, cspm_pkg::KIND_EXACT, cspm_pkg::KIND_EXACT,
			cspm_pkg::KIND_EXACT, cspm_pkg::KIND_EXACT, cspm_pkg::KIND_EVERY));
		send_request(mk_req(1'b1, 3, 15, 12, 30, 45,
			KIND_CODE3, KIND_CODE3, KIND_CODE3, KIND_CODE3, KIND_CODE3));
		send_request(mk_req(1'b1, 0, 0, 0, 0, 0, cspm_pkg::KIND_EVERY, cspm_pkg::KIND_EVERY,
			cspm_pkg::KIND_EVERY, cspm_pkg::KIND_EVERY, cspm_pkg::KIND_EVERY));
		send_request(mk_req(1'b1, 7, 31, 31, 63, 63, cspm_pkg::KIND_ANY, cspm_pkg::KIND_ANY,
			cspm_pkg::KIND_ANY, cspm_pkg::KIND_ANY, cspm_pkg::KIND_ANY));
		send_request(mk_req(1'b1, 0, 0, 0, 0, 60, cspm_pkg::KIND_EXACT, cspm_pkg::KIND_ANY,
			cspm_pkg::KIND_EVERY, KIND_CODE3, cspm_pkg::KIND_EXACT));
		send_request(mk_req(1'b1, 2, 0, 0, 0, 0, cspm_pkg::KIND_EXACT, cspm_pkg::KIND_EXACT,
			cspm_pkg::KIND_EXACT, cspm_pkg::KIND_EXACT, cspm_pkg::KIND_EXACT));
		send_request(mk_req(1'b1, 6, 0, 0, 0, 33, cspm_pkg::KIND_EXACT, cspm_pkg::KIND_EXACT,
			cspm_pkg::KIND_EXACT, cspm_pkg::KIND_EXACT, cspm_pkg::KIND_EXACT));
		send_request(mk_req(1'b1, 5, 31, 23, 0, 0, cspm_pkg::KIND_EVERY,
			cspm_pkg::KIND_EVERY, cspm_pkg::KIND_EVERY, cspm_pkg::KIND_EVERY,
			cspm_pkg::KIND_EVERY));
		send_request(mk_req(1'b1, 4, 20, 18, 45, 30, cspm_pkg::KIND_EXACT,
			cspm_pkg::KIND_EXACT, cspm_pkg::KIND_EXACT, cspm_pkg::KIND_EXACT,
			cspm_pkg::KIND_EXACT));
		send_request(mk_req(1'b1, 1, 1, 1, 1, 1, cspm_pkg::KIND_EXACT, cspm_pkg::KIND_EXACT,
			cspm_pkg::KIND_EXACT, cspm_pkg::KIND_EXACT, cspm_pkg::KIND_EXACT));
		inserts_sent = 10;

		// The table fills up to one slot short; inserts in this loop keep at least one pinned unit.
		for (int i = 0; i < 300; i++) begin
			if (inserts_sent < cspm_pkg::TABLE_DEPTH_DEF - 1 && $urandom_range(0, 5) == 0) begin
				r = random_req(1'b0);
				r.kind[$urandom_range(1, 4)] = cspm_pkg::KIND_EVERY;
				inserts_sent++;
			end else if ($urandom_range(0, 9) < 7) begin
				r = aimed_tick();
			end else begin
				r = random_req(1'b1);
			end
			send_request(r);
		end
		while (inserts_sent < cspm_pkg::TABLE_DEPTH_DEF - 1) begin
			send_request(random_req(1'b0));
			inserts_sent++;
		end

		// The last slot takes a pure wildcard entry, so every tick matches from here on.
		send_request(mk_req(1'b0, 1, 2, 3, 4, 5, cspm_pkg::KIND_ANY, KIND_CODE3,
			cspm_pkg::KIND_ANY, KIND_CODE3, cspm_pkg::KIND_ANY));

		for (int i = 0; i < 150; i++) begin
			idle_on = (i < 60);
			if ($urandom_range(0, 19) < 3) begin
				r = random_req(1'b0);
			end else if ($urandom_range(0, 9) < 6) begin
				r = aimed_tick();
			end else begin
				r = random_req(1'b1);
			end
			send_request(r);
		end
		in_valid <= 1'b0;
		@(posedge clk);

		while (tracker.pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (tracker.errors == 0) begin
			$display("** cron_schedule_matcher_core: PASSED **");
		end else begin
			$display("** cron_schedule_matcher_core: FAILED **");
		end
		$finish;
	end

endmodule
